FILE: hw/rtl/sbl_pkg.sv
// ----------------------------------------------------------------------------
// sbl_pkg
// Shared types and constants of the Sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sbl_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int WIDTH_RESET    = 640;
    localparam int HEIGHT_RESET   = 480;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_IDX_W      = 1;
    localparam int PIX_W          = 24;
    localparam int CAP_LIMIT      = 65025;
    localparam int MAG_MAX        = 255;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef logic [8:0][7:0] nbhd_t;

    typedef struct packed {
        logic       done;
        logic [7:0] mag;
    } lane_status_t;

endpackage

FILE: hw/rtl/sbl_ram.sv
// ----------------------------------------------------------------------------
// sbl_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module sbl_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/sbl_lane.sv
// ----------------------------------------------------------------------------
// sbl_lane
// One color channel: Sobel gradients, sum of squares, and a rounded, capped
// square root found one result bit per cycle.
// ----------------------------------------------------------------------------
module sbl_lane
    import sbl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  nbhd_t        nbhd,
    output lane_status_t status
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_SQUARE,
        L_ROOT,
        L_ROUND,
        L_DONE
    } lane_state_t;

    lane_state_t        state_reg;
    logic signed [10:0] gx_reg;
    logic signed [10:0] gy_reg;
    logic [20:0]        sum_reg;
    logic [2:0]         step_reg;
    logic [8:0]         rem_reg;
    logic [7:0]         root_reg;
    logic [7:0]         mag_reg;

    logic signed [10:0] gx_next;
    logic signed [10:0] gy_next;
    logic signed [21:0] sq_next;
    logic [1:0]         pair;
    logic [10:0]        rem_shift;
    logic [10:0]        trial;
    logic [10:0]        diff;
    logic               fits;

    always_comb begin
        gx_next = 11'(signed'({3'b0, nbhd[2]})) + 11'(signed'({2'b0, nbhd[5], 1'b0}))
                + 11'(signed'({3'b0, nbhd[8]})) - 11'(signed'({3'b0, nbhd[0]}))
                - 11'(signed'({2'b0, nbhd[3], 1'b0})) - 11'(signed'({3'b0, nbhd[6]}));
        gy_next = 11'(signed'({3'b0, nbhd[6]})) + 11'(signed'({2'b0, nbhd[7], 1'b0}))
                + 11'(signed'({3'b0, nbhd[8]})) - 11'(signed'({3'b0, nbhd[0]}))
                - 11'(signed'({2'b0, nbhd[1], 1'b0})) - 11'(signed'({3'b0, nbhd[2]}));
        sq_next   = gx_reg * gx_reg + gy_reg * gy_reg;
        pair      = sum_reg[{step_reg, 1'b1} -: 2];
        rem_shift = {rem_reg, pair};
        trial     = {1'b0, root_reg, 2'b01};
        fits      = rem_shift >= trial;
        diff      = rem_shift - trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE, L_DONE: begin
                    if (start) begin
                        gx_reg    <= gx_next;
                        gy_reg    <= gy_next;
                        state_reg <= L_SQUARE;
                    end
                end
                L_SQUARE: begin
                    sum_reg   <= sq_next[20:0];
                    step_reg  <= 3'd7;
                    rem_reg   <= '0;
                    root_reg  <= '0;
                    state_reg <= L_ROOT;
                end
                L_ROOT: begin
                    rem_reg   <= fits ? diff[8:0] : rem_shift[8:0];
                    root_reg  <= {root_reg[6:0], fits};
                    step_reg  <= step_reg - 3'd1;
                    if (step_reg == 3'd0) begin
                        state_reg <= L_ROUND;
                    end
                end
                L_ROUND: begin
                    if (32'(sum_reg) >= CAP_LIMIT) begin
                        mag_reg <= 8'(MAG_MAX);
                    end else begin
                        mag_reg <= root_reg + 8'(rem_reg > {1'b0, root_reg});
                    end
                    state_reg <= L_DONE;
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

    assign status.done = (state_reg == L_DONE);
    assign status.mag  = mag_reg;

endmodule

FILE: hw/rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb
// 3x3 Sobel edge magnitude per color channel on a raster RGB pixel stream.
// ----------------------------------------------------------------------------
// Each request is accepted in the idle state, where the line RAM read of the
// two stored rows is issued; the read state then shifts the window and writes
// the RAM back. A request that yields a result then starts three channel lanes
// in parallel, each squaring its gradients and finding the square root one bit
// per cycle. Results lag the pixels by one row plus one pixel, so width+1
// flush requests after the last pixel drain the frame. A finished result
// waits in an output register while the next request is taken. Any
// configuration write restarts the frame and drops pending results.
module sobel_edge_magnitude_rgb
    import sbl_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_kind,
    input  logic [7:0]            s_red,
    input  logic [7:0]            s_green,
    input  logic [7:0]            s_blue,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [7:0]            m_edge_red,
    output logic [7:0]            m_edge_green,
    output logic [7:0]            m_edge_blue,
    output logic                  m_row_end,
    output logic                  m_frame_end
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    typedef enum logic [1:0] {
        T_IDLE,
        T_READ,
        T_CALC
    } top_state_t;

    top_state_t       state_reg;
    logic [WID_W-1:0] width_reg;
    logic [HGT_W-1:0] height_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [ROW_W-1:0] in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] pix_reg;
    logic             row_end_reg;
    logic             frame_end_reg;
    logic             m_valid_reg;
    logic [7:0]       red_reg;
    logic [7:0]       green_reg;
    logic [7:0]       blue_reg;
    logic             m_row_end_reg;
    logic             m_frame_end_reg;

    logic [2*PIX_W-1:0] ram_rdata;
    logic [PIX_W-1:0]   win_next [9];
    logic [PIX_W-1:0]   nb [9];
    nbhd_t              lane_nbhd [3];
    lane_status_t       lane_status [3];
    logic               lane_start;
    logic               lanes_done;
    logic               out_free;
    logic               emit;
    logic               in_col_last;
    logic               out_col_last;
    logic               out_row_last;
    logic [WID_W-1:0]   width_wr;
    logic [HGT_W-1:0]   height_wr;

    sbl_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (state_reg == T_READ),
        .waddr (in_col_reg),
        .wdata ({ram_rdata[PIX_W-1:0], pix_reg}),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    always_comb begin
        if (cfg_wdata == '0) begin
            width_wr  = WID_W'(1);
            height_wr = HGT_W'(1);
        end else begin
            width_wr  = (32'(cfg_wdata) > MAX_WIDTH) ? WID_W'(MAX_WIDTH) : WID_W'(cfg_wdata);
            height_wr = (32'(cfg_wdata) > MAX_HEIGHT) ? HGT_W'(MAX_HEIGHT)
                                                      : HGT_W'(cfg_wdata);
        end
    end

    always_comb begin
        in_col_last  = (32'(in_col_reg) + 32'd1 >= 32'(width_reg));
        out_col_last = (32'(out_col_reg) + 32'd1 >= 32'(width_reg));
        out_row_last = (32'(out_row_reg) + 32'd1 >= 32'(height_reg));
        emit = (32'(in_row_reg) >= 32'd2)
            || ((32'(in_row_reg) == 32'd1) && (in_col_reg != '0));
        for (int r = 0; r < 3; r++) begin
            win_next[3*r]     = win_reg[3*r+1];
            win_next[3*r + 1] = win_reg[3*r+2];
        end
        win_next[2] = ram_rdata[2*PIX_W-1:PIX_W];
        win_next[5] = ram_rdata[PIX_W-1:0];
        win_next[8] = pix_reg;
        for (int k = 0; k < 9; k++) begin
            if (((k / 3 == 0) && (out_row_reg == '0)) || ((k / 3 == 2) && out_row_last)
                    || ((k % 3 == 0) && (out_col_reg == '0))
                    || ((k % 3 == 2) && out_col_last)) begin
                nb[k] = '0;
            end else begin
                nb[k] = win_next[k];
            end
        end
        for (int c = 0; c < 3; c++) begin
            for (int k = 0; k < 9; k++) begin
                lane_nbhd[c][k] = nb[k][PIX_W-1-8*c -: 8];
            end
        end
    end

    assign lane_start = (state_reg == T_READ) && emit;
    assign lanes_done = lane_status[0].done && lane_status[1].done && lane_status[2].done;
    assign out_free   = !m_valid_reg || m_ready;

    for (genvar g = 0; g < 3; g++) begin : g_lane
        sbl_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .start   (lane_start),
            .nbhd    (lane_nbhd[g]),
            .status  (lane_status[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= T_IDLE;
            width_reg   <= WID_W'(W_RST);
            height_reg  <= HGT_W'(H_RST);
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= width_wr;
                REG_IMAGE_HEIGHT: height_reg <= height_wr;
                default: ;
            endcase
            state_reg   <= T_IDLE;
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else begin
            if (m_valid_reg && m_ready && !((state_reg == T_CALC) && lanes_done)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                T_IDLE: begin
                    if (s_valid) begin
                        if (!s_kind && (32'(in_row_reg) < 32'(height_reg))) begin
                            pix_reg <= {s_red, s_green, s_blue};
                        end else begin
                            pix_reg <= '0;
                        end
                        state_reg <= T_READ;
                    end
                end
                T_READ: begin
                    row_end_reg   <= out_col_last;
                    frame_end_reg <= out_col_last && out_row_last;
                    if (emit && out_col_last && out_row_last) begin
                        in_col_reg  <= '0;
                        in_row_reg  <= '0;
                        out_col_reg <= '0;
                        out_row_reg <= '0;
                        for (int k = 0; k < 9; k++) begin
                            win_reg[k] <= '0;
                        end
                    end else begin
                        for (int k = 0; k < 9; k++) begin
                            win_reg[k] <= win_next[k];
                        end
                        if (in_col_last) begin
                            in_col_reg <= '0;
                            in_row_reg <= in_row_reg + ROW_W'(1);
                        end else begin
                            in_col_reg <= in_col_reg + COL_W'(1);
                        end
                        if (emit) begin
                            if (out_col_last) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + ROW_W'(1);
                            end else begin
                                out_col_reg <= out_col_reg + COL_W'(1);
                            end
                        end
                    end
                    state_reg <= emit ? T_CALC : T_IDLE;
                end
                T_CALC: begin
                    if (lanes_done && out_free) begin
                        m_valid_reg     <= 1'b1;
                        red_reg         <= lane_status[0].mag;
                        green_reg       <= lane_status[1].mag;
                        blue_reg        <= lane_status[2].mag;
                        m_row_end_reg   <= row_end_reg;
                        m_frame_end_reg <= frame_end_reg;
                        state_reg       <= T_IDLE;
                    end
                end
                default: state_reg <= T_IDLE;
            endcase
        end
    end

    assign s_ready      = (state_reg == T_IDLE) && !cfg_we;
    assign m_valid      = m_valid_reg;
    assign m_edge_red   = red_reg;
    assign m_edge_green = green_reg;
    assign m_edge_blue  = blue_reg;
    assign m_row_end    = m_row_end_reg;
    assign m_frame_end  = m_frame_end_reg;

`ifndef ASSERT_OFF
    a_frame_end_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_end |-> m_row_end)
        else $error("Frame end without row end.");

    a_calc_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == T_CALC) && lanes_done && out_free && !cfg_we |=> m_valid)
        else $error("Finished lanes did not load the output register.");

    a_input_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(in_row_reg) <= 32'(height_reg) + 32'd1)
        else $error("Input row ran past the frame drain.");

    a_lanes_idle_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !m_valid_reg || lanes_done || (state_reg == T_IDLE))
        else $error("Request accepted outside the idle state.");
`endif

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Sobel edge magnitude testbench
// Drives whole RGB frames of random size and content through the block, with
// malformed flush and drain requests mixed in. A model of the line stores and
// the 3x3 window predicts each result a directed row does not give, and the
// result channel is checked field by field. Both handshakes stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import sbl_pkg::*;

    localparam int RUN_LIMIT = 1500000;
    localparam int DRAIN_WAIT = 40;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       row_end;
        logic       frame_end;
    } edge_result_t;

    typedef struct {
        int           set_w;
        int           set_h;
        logic         kind;
        logic [7:0]   red;
        logic [7:0]   green;
        logic [7:0]   blue;
        bit           typed;
        edge_result_t want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_kind;
    logic [7:0]            s_red;
    logic [7:0]            s_green;
    logic [7:0]            s_blue;
    logic                  m_valid;
    logic                  m_ready;
    logic [7:0]            m_edge_red;
    logic [7:0]            m_edge_green;
    logic [7:0]            m_edge_blue;
    logic                  m_row_end;
    logic                  m_frame_end;

    // Model of the block's state.
    logic [PIX_W-1:0] upper_line[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] middle_line[MAX_WIDTH_DEF];
    logic [PIX_W-1:0] window_px[9];
    int               frame_w;
    int               frame_h;
    int               in_row;
    int               in_col;
    int               out_row;
    int               out_col;

    edge_result_t pending_edges[$];
    bit           failed;
    bit           no_idle;
    bit           hold_request;
    int           requests_sent;
    int           cycle_count;

    sobel_edge_magnitude_rgb dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_red        (s_red),
        .s_green      (s_green),
        .s_blue       (s_blue),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_edge_red   (m_edge_red),
        .m_edge_green (m_edge_green),
        .m_edge_blue  (m_edge_blue),
        .m_row_end    (m_row_end),
        .m_frame_end  (m_frame_end)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > RUN_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (no_idle || roll < 50) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 30);
    endfunction

    function automatic void restart_frame();
        for (int k = 0; k < 9; k++) window_px[k] = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
    endfunction

    function automatic int clamp_size(int value);
        if (value < 1) return 1;
        if (value > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
        return value;
    endfunction

    function automatic logic [7:0] edge_mag(int gx, int gy);
        int sum;
        int root;
        int probe;
        sum = gx * gx + gy * gy;
        if (sum >= CAP_LIMIT) return 8'(MAG_MAX);
        root = 0;
        for (probe = 128; probe > 0; probe = probe >> 1) begin
            if ((root | probe) * (root | probe) <= sum) root = root | probe;
        end
        if (sum > root * root + root) root++;
        return root[7:0];
    endfunction

    function automatic bit predict_edge(input logic kind, input logic [7:0] red,
                                        input logic [7:0] green, input logic [7:0] blue,
                                        output edge_result_t res);
        int               pos;
        int               gx;
        int               gy;
        int               val;
        bit               off;
        bit               last;
        logic [PIX_W-1:0] pix;
        logic [PIX_W-1:0] nb[9];
        logic [7:0]       mags[3];
        pos = in_row * frame_w + in_col;
        pix = '0;
        if (!kind && pos < frame_w * frame_h) pix = {red, green, blue};
        for (int r = 0; r < 3; r++) begin
            window_px[r * 3] = window_px[r * 3 + 1];
            window_px[r * 3 + 1] = window_px[r * 3 + 2];
        end
        window_px[2] = upper_line[in_col];
        window_px[5] = middle_line[in_col];
        window_px[8] = pix;
        upper_line[in_col] = middle_line[in_col];
        middle_line[in_col] = pix;
        in_col++;
        if (in_col >= frame_w) begin
            in_col = 0;
            in_row++;
        end
        if (pos < frame_w + 1) return 0;

        for (int k = 0; k < 9; k++) begin
            off = (k / 3 == 0 && out_row == 0) || (k / 3 == 2 && out_row + 1 >= frame_h)
                || (k % 3 == 0 && out_col == 0) || (k % 3 == 2 && out_col + 1 >= frame_w);
            nb[k] = off ? '0 : window_px[k];
        end
        for (int ch = 0; ch < 3; ch++) begin
            gx = 0;
            gy = 0;
            for (int k = 0; k < 9; k++) begin
                val = (nb[k] >> (16 - 8 * ch)) & 8'hFF;
                gx += val * ((k % 3) - 1) * ((k / 3 == 1) ? 2 : 1);
                gy += val * ((k / 3) - 1) * ((k % 3 == 1) ? 2 : 1);
            end
            mags[ch] = edge_mag(gx, gy);
        end
        last = (out_col + 1 >= frame_w) && (out_row + 1 >= frame_h);
        res.red = mags[0];
        res.green = mags[1];
        res.blue = mags[2];
        res.row_end = (out_col + 1 >= frame_w);
        res.frame_end = last;
        if (last) begin
            restart_frame();
        end else begin
            out_col++;
            if (out_col >= frame_w) begin
                out_col = 0;
                out_row++;
            end
        end
        return 1;
    endfunction

    // Called right after a rising edge; returns right after the accepting edge.
    task automatic send_request(input logic kind, input logic [7:0] red,
                                input logic [7:0] green, input logic [7:0] blue,
                                input bit typed, input edge_result_t want);
        int           gap;
        edge_result_t res;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_red <= red;
        s_green <= green;
        s_blue <= blue;
        do @(posedge aclk); while (!s_ready);
        requests_sent++;
        if (predict_edge(kind, red, green, blue, res)) begin
            pending_edges.push_back(typed ? want : res);
        end
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t index, input int value);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value[CFG_DATA_W-1:0];
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (index == REG_IMAGE_WIDTH) frame_w = clamp_size(value);
        else frame_h = clamp_size(value);
        restart_frame();
    endtask

    function automatic logic [7:0] pick_sample();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // One frame plus its drain; noise adds flush requests inside the frame and
    // pixel requests during the drain.
    task automatic run_frame();
        edge_result_t none;
        logic         kind;
        none = '{default: '0};
        for (int i = 0; i < frame_w * frame_h + frame_w + 1; i++) begin
            if (i < frame_w * frame_h) kind = ($urandom_range(0, 19) == 0);
            else kind = ($urandom_range(0, 4) != 0);
            send_request(kind, pick_sample(), pick_sample(), pick_sample(), 1'b0, none);
        end
    endtask

    always @(posedge aclk) begin
        edge_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_edges.size() == 0) begin
                $display("%0t: result with none expected", $time);
                failed = 1'b1;
            end else begin
                want = pending_edges.pop_front();
                if ({m_edge_red, m_edge_green, m_edge_blue, m_row_end, m_frame_end} !==
                    {want.red, want.green, want.blue, want.row_end, want.frame_end}) begin
                    $display("%0t: mismatch expected r=%h g=%h b=%h row=%b frame=%b",
                             $time, want.red, want.green, want.blue, want.row_end,
                             want.frame_end);
                    $display("%0t:            actual r=%h g=%h b=%h row=%b frame=%b",
                             $time, m_edge_red, m_edge_green, m_edge_blue, m_row_end,
                             m_frame_end);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        int stall_left;
        m_ready <= 1'b0;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left = 600;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    initial begin
        directed_row_t rows[$];
        edge_result_t  zero_corner;
        edge_result_t  none;
        int            phase_frames;
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_IMAGE_WIDTH;
        cfg_wdata <= '0;
        s_valid <= 1'b0;
        s_kind <= 1'b0;
        s_red <= '0;
        s_green <= '0;
        s_blue <= '0;
        failed = 1'b0;
        no_idle = 1'b0;
        hold_request = 1'b0;
        requests_sent = 0;
        frame_w = WIDTH_RESET;
        frame_h = HEIGHT_RESET;
        for (int c = 0; c < MAX_WIDTH_DEF; c++) begin
            upper_line[c] = '0;
            middle_line[c] = '0;
        end
        restart_frame();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset size: the first result appears only after one row plus one pixel.
        none = '{default: '0};
        for (int i = 0; i < frame_w + 2; i++) begin
            send_request(1'b0, pick_sample(), pick_sample(), pick_sample(), 1'b0, none);
        end
        wait_idle();

        // A lone pixel has every neighbor outside the frame, so its edge is zero.
        zero_corner = '{red: 8'h00, green: 8'h00, blue: 8'h00, row_end: 1'b1,
                        frame_end: 1'b1};
        rows = '{
            '{0, 0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, zero_corner},
            '{-1, -1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, zero_corner},
            '{-1, -1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, zero_corner},
            '{-1, -1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'h55, 8'hAA, 8'h0F, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'hC8, 8'h37, 8'hF0, 1'b1, zero_corner},
            '{3, 2, 1'b0, 8'hFF, 8'h00, 8'hFF, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'h00, 8'hFF, 8'h00, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'hFF, 8'hFF, 8'h00, 1'b0, zero_corner},
            '{-1, -1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'h00, 8'h80, 8'h01, 1'b0, zero_corner},
            '{-1, -1, 1'b1, 8'h00, 8'h00, 8'h00, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 1'b0, zero_corner},
            '{-1, -1, 1'b1, 8'h12, 8'h34, 8'h56, 1'b0, zero_corner},
            '{-1, -1, 1'b0, 8'h7F, 8'hFE, 8'h80, 1'b0, zero_corner}
        };
        foreach (rows[i]) begin
            if (rows[i].set_w >= 0) begin
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, rows[i].set_w);
                write_reg(REG_IMAGE_HEIGHT, rows[i].set_h);
            end
            send_request(rows[i].kind, rows[i].red, rows[i].green, rows[i].blue,
                         rows[i].typed, rows[i].want);
        end
        wait_idle();

        hold_request = 1'b1;
        while (requests_sent < 800) begin
            no_idle = ($urandom_range(0, 3) == 0);
            write_reg(REG_IMAGE_WIDTH, ($urandom_range(0, 4) == 0) ?
                      $urandom_range(1, 40) : $urandom_range(1, 8));
            write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 6));
            phase_frames = $urandom_range(1, 3);
            repeat (phase_frames) run_frame();
            wait_idle();
        end
        no_idle = 1'b0;

        if (!failed) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
